// File: rtl/text_terminal_escape_cursor_engine_unit_macros.svh
// assertion macros for the text terminal escape and cursor engine
// no dependencies; taken in by the files that carry concurrent checks
`ifndef TEXT_TERMINAL_ESCAPE_CURSOR_ENGINE_UNIT_MACROS_SVH
`define TEXT_TERMINAL_ESCAPE_CURSOR_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TTECU_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error(msg);
`define TTECU_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error(msg);
`else
`define TTECU_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg)
`define TTECU_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg)
`endif
`endif

// File: rtl/ttecu_pkg.sv
// shared types, constants and codes of the text terminal escape and cursor engine
// no dependencies; used by ttecu_step and the top level
package ttecu_pkg;

    // parser phase; code 3 is unused and handled as a broken sequence
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NARROW = 2'd0,
        KIND_WIDE   = 2'd1,
        KIND_SCROLL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [9:0]  column;
        logic [7:0]  row;
        logic [15:0] glyph_code;
        logic [2:0]  fg_index;
        logic [2:0]  bg_index;
        logic        last;
    } t_result;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  lead_byte;
        logic [7:0]  first_param;
        logic        past_first_param;
        logic [2:0]  fg_color;
        logic [2:0]  bg_color;
        logic [9:0]  cursor_col;
        logic [7:0]  cursor_row;
    } t_state;

    typedef struct packed {
        t_state      state;
        logic [1:0]  count;
        t_result     res0;
        t_result     res1;
    } t_step;

    // configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [9:0] COLS_RESET = 10'd80;
    localparam logic [9:0] COLS_MIN   = 10'd2;
    localparam logic [9:0] COLS_MAX   = 10'd512;
    localparam logic [8:0] ROWS_RESET = 9'd25;
    localparam logic [8:0] ROWS_MIN   = 9'd1;
    localparam logic [8:0] ROWS_MAX   = 9'd256;

    localparam int TAB_STOP = 4;

    localparam logic [7:0] LEAD_MIN      = 8'hA0;
    localparam logic [7:0] ESC_BYTE      = 8'h3F;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_SEMI     = 8'h3B;
    localparam logic [7:0] CHAR_M        = 8'h6D;
    localparam logic [7:0] CHAR_0        = 8'h30;
    localparam logic [7:0] CHAR_9        = 8'h39;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_NUL      = 8'h00;

    localparam logic [7:0] FG_BASE = 8'd10;
    localparam logic [7:0] FG_TOP  = 8'd15;
    localparam logic [7:0] BG_BASE = 8'd20;
    localparam logic [7:0] BG_TOP  = 8'd25;
    localparam logic [7:0] PARAM_MAX = 8'd255;

    localparam logic [2:0] COLOR_DEFAULT = 3'd6;

endpackage

// File: rtl/ttecu_step.sv
// one byte of work: escape parser, double-width pairing and cursor update
// combinational; depends on ttecu_pkg
module ttecu_step (
    input  ttecu_pkg::t_state i_state,
    input  logic [7:0]        i_byte,
    input  logic [9:0]        i_width,
    input  logic [8:0]        i_height,
    output ttecu_pkg::t_step  o_step
);

    ttecu_pkg::t_state  st;
    ttecu_pkg::t_result scroll_res;
    ttecu_pkg::t_result draw_res;
    ttecu_pkg::t_result res0;
    ttecu_pkg::t_result res1;
    logic        consumed;
    logic        wide;
    logic        pre_scroll;
    logic [1:0]  cnt;
    logic [11:0] fp_calc;
    logic [10:0] col;
    logic [10:0] rem;
    logic [8:0]  row;
    logic [8:0]  h_m1;
    logic [9:0]  limit;

    assign h_m1 = i_height - 9'd1;

    always_comb begin
        st         = i_state;
        consumed   = 1'b0;
        wide       = 1'b0;
        pre_scroll = 1'b0;
        cnt        = 2'd0;
        rem        = '0;
        limit      = i_width;
        fp_calc    = {4'b0, i_state.first_param} * 12'd10
                   + {8'b0, 4'(i_byte - ttecu_pkg::CHAR_0)};

        // parser
        if (i_byte > ttecu_pkg::LEAD_MIN && i_state.lead_byte == 8'd0) begin
            st.lead_byte        = i_byte;
            st.phase            = ttecu_pkg::PH_IDLE;
            st.past_first_param = 1'b0;
            consumed            = 1'b1;
        end else begin
            case (i_state.phase)
                ttecu_pkg::PH_IDLE: begin
                    if (i_byte == ttecu_pkg::ESC_BYTE) begin
                        st.phase = ttecu_pkg::PH_ESC;
                        consumed = 1'b1;
                    end
                end
                ttecu_pkg::PH_ESC: begin
                    if (i_byte == ttecu_pkg::CHAR_LBRACKET) begin
                        st.first_param      = 8'd0;
                        st.past_first_param = 1'b0;
                        st.phase            = ttecu_pkg::PH_PARAM;
                        consumed            = 1'b1;
                    end
                end
                ttecu_pkg::PH_PARAM: begin
                    if (i_byte == ttecu_pkg::CHAR_SEMI) begin
                        st.past_first_param = 1'b1;
                        consumed            = 1'b1;
                    end else if (i_byte == ttecu_pkg::CHAR_M) begin
                        if (i_state.first_param == 8'd0) begin
                            st.fg_color = ttecu_pkg::COLOR_DEFAULT;
                            st.bg_color = ttecu_pkg::COLOR_DEFAULT;
                        end else if (i_state.first_param inside
                                     {[ttecu_pkg::FG_BASE:ttecu_pkg::FG_TOP]}) begin
                            st.fg_color = 3'(i_state.first_param - ttecu_pkg::FG_BASE);
                        end else if (i_state.first_param inside
                                     {[ttecu_pkg::BG_BASE:ttecu_pkg::BG_TOP]}) begin
                            st.bg_color = 3'(i_state.first_param - ttecu_pkg::BG_BASE);
                        end
                        st.phase            = ttecu_pkg::PH_IDLE;
                        st.past_first_param = 1'b0;
                        consumed            = 1'b1;
                    end else if (i_byte inside {[ttecu_pkg::CHAR_0:ttecu_pkg::CHAR_9]}) begin
                        if (!i_state.past_first_param) begin
                            st.first_param = (fp_calc > {4'b0, ttecu_pkg::PARAM_MAX})
                                           ? ttecu_pkg::PARAM_MAX : fp_calc[7:0];
                        end
                        consumed = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!consumed) begin
                st.phase            = ttecu_pkg::PH_IDLE;
                st.past_first_param = 1'b0;
            end
        end

        // cursor and commands
        col = {1'b0, i_state.cursor_col};
        row = {1'b0, i_state.cursor_row};

        scroll_res            = '0;
        scroll_res.kind       = ttecu_pkg::KIND_SCROLL;
        scroll_res.fg_index   = i_state.fg_color;
        scroll_res.bg_index   = i_state.bg_color;
        draw_res              = scroll_res;
        res0                  = scroll_res;
        res1                  = scroll_res;

        if (!consumed && i_byte != ttecu_pkg::CHAR_NUL) begin
            if (i_byte == ttecu_pkg::CHAR_LF || i_byte == ttecu_pkg::CHAR_TAB) begin
                if (i_byte == ttecu_pkg::CHAR_LF) begin
                    col = '0;
                    row = row + 9'd1;
                end else begin
                    rem = 11'(col % ttecu_pkg::TAB_STOP);
                    if (rem != 11'd0) begin
                        col = col + 11'(ttecu_pkg::TAB_STOP) - rem;
                    end
                    if (col > {1'b0, i_width}) begin
                        col = col - {1'b0, i_width};
                        row = row + 9'd1;
                    end
                end
                if (row >= i_height) begin
                    row = h_m1;
                    cnt = 2'd1;
                end
            end else begin
                // a byte above the lead threshold here always has a lead held
                wide  = i_byte > ttecu_pkg::LEAD_MIN;
                limit = wide ? i_width - 10'd1 : i_width;
                if (col >= {1'b0, limit}) begin
                    col = '0;
                    row = row + 9'd1;
                end
                if (row >= i_height) begin
                    pre_scroll = 1'b1;
                    row        = h_m1;
                end
                draw_res.column = col[9:0];
                draw_res.row    = row[7:0];
                if (wide) begin
                    draw_res.kind       = ttecu_pkg::KIND_WIDE;
                    draw_res.glyph_code = {i_state.lead_byte, i_byte};
                    st.lead_byte        = 8'd0;
                    col                 = col + 11'd2;
                end else begin
                    draw_res.kind       = ttecu_pkg::KIND_NARROW;
                    draw_res.glyph_code = {8'd0, i_byte};
                    col                 = col + 11'd1;
                end
                if (pre_scroll) begin
                    res1 = draw_res;
                    cnt  = 2'd2;
                end else begin
                    res0 = draw_res;
                    cnt  = 2'd1;
                end
            end
            st.cursor_col = col[9:0];
            st.cursor_row = row[7:0];
        end

        res0.last = (cnt == 2'd1);
        res1.last = 1'b1;
    end

    assign o_step.state = st;
    assign o_step.count = cnt;
    assign o_step.res0  = res0;
    assign o_step.res1  = res1;

endmodule

// File: rtl/text_terminal_escape_cursor_engine_unit.sv
// top level of the text terminal escape and cursor engine: state, config, result buffering
// depends on ttecu_pkg, ttecu_step and text_terminal_escape_cursor_engine_unit_macros.svh
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   input   | in        | i_in_valid / o_in_ready    | i_char_byte
//   output  | out       | o_out_valid / i_out_ready  | o_kind .. o_last, up to 2 per byte
//   config  | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// one byte a cycle: the whole parse and cursor step sits between the state
// registers and a two-slot result register, and a byte is taken whenever that
// register is empty or drains its last slot in the same cycle.
// a byte that gives a scroll and a draw takes two output transfers.
// results pass the pending slots and then the output register; reset is synchronous
// and needs no clearing pass. an output stall holds the result register, then input.
`include "text_terminal_escape_cursor_engine_unit_macros.svh"

module text_terminal_escape_cursor_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [9:0]  o_column,
    output logic [7:0]  o_row,
    output logic [15:0] o_glyph_code,
    output logic [2:0]  o_fg_index,
    output logic [2:0]  o_bg_index,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    ttecu_pkg::t_state  r_state;
    ttecu_pkg::t_step   step;
    ttecu_pkg::t_result r_p0, n_p0;
    ttecu_pkg::t_result r_p1, n_p1;
    ttecu_pkg::t_result r_o;
    logic [1:0] r_p_cnt, n_p_cnt;
    logic       r_o_valid;
    logic [9:0] r_columns;
    logic [8:0] r_rows;
    logic [9:0] width;
    logic [8:0] height;
    logic       move;
    logic       in_acc;

    assign width  = (r_columns < ttecu_pkg::COLS_MIN) ? ttecu_pkg::COLS_MIN :
                    (r_columns > ttecu_pkg::COLS_MAX) ? ttecu_pkg::COLS_MAX : r_columns;
    assign height = (r_rows < ttecu_pkg::ROWS_MIN) ? ttecu_pkg::ROWS_MIN :
                    (r_rows > ttecu_pkg::ROWS_MAX) ? ttecu_pkg::ROWS_MAX : r_rows;

    ttecu_step u_step (
        .i_state  (r_state),
        .i_byte   (i_char_byte),
        .i_width  (width),
        .i_height (height),
        .o_step   (step)
    );

    // pending slot moves into the output register when that is free or taken
    assign move       = (r_p_cnt != 2'd0) && (!r_o_valid || i_out_ready);
    assign o_in_ready = (r_p_cnt == 2'd0) || (r_p_cnt == 2'd1 && move);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_p_cnt = r_p_cnt;
        n_p0    = r_p0;
        n_p1    = r_p1;
        if (in_acc) begin
            n_p_cnt = step.count;
            n_p0    = step.res0;
            n_p1    = step.res1;
        end else if (move) begin
            n_p_cnt = r_p_cnt - 2'd1;
            n_p0    = r_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= ttecu_pkg::COLS_RESET;
            r_rows    <= ttecu_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ttecu_pkg::CFG_COLUMNS: r_columns <= i_cfg_data;
                ttecu_pkg::CFG_ROWS:    r_rows    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= ttecu_pkg::PH_IDLE;
            r_state.lead_byte        <= 8'd0;
            r_state.first_param      <= 8'd0;
            r_state.past_first_param <= 1'b0;
            r_state.fg_color         <= ttecu_pkg::COLOR_DEFAULT;
            r_state.bg_color         <= ttecu_pkg::COLOR_DEFAULT;
            r_state.cursor_col       <= 10'd0;
            r_state.cursor_row       <= 8'd0;
        end else if (in_acc) begin
            r_state <= step.state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_cnt   <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_cnt <= n_p_cnt;
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        if (move) begin
            r_o <= r_p0;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_kind       = r_o.kind;
    assign o_column     = r_o.column;
    assign o_row        = r_o.row;
    assign o_glyph_code = r_o.glyph_code;
    assign o_fg_index   = r_o.fg_index;
    assign o_bg_index   = r_o.bg_index;
    assign o_last       = r_o.last;

    // a held pair cannot drain both slots at once
    `TTECU_ASSERT_NXT(a_pair_holds, i_clk, i_rst_n, r_p_cnt == 2'd2, r_p_cnt != 2'd0,
                      "pair lost")
    // the first of a pair is followed at once by the second
    `TTECU_ASSERT_NXT(a_pair_follows, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last,
                      o_out_valid, "second result missing")
    // scroll commands carry no cell or glyph
    `TTECU_ASSERT_IMP(a_scroll_zero, i_clk, i_rst_n,
                      r_o_valid && r_o.kind == ttecu_pkg::KIND_SCROLL,
                      r_o.column == 10'd0 && r_o.row == 8'd0 && r_o.glyph_code == 16'd0,
                      "scroll payload not zero")

endmodule
